FILE: hdl/rfalu_pkg.sv
`default_nettype none
package rfalu_pkg;

	localparam int DATA_W = 16;
	localparam int SEL_W = 3;
	localparam int FUNC_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [FUNC_W-1:0] OP_TSF = 4'd0;
	localparam logic [FUNC_W-1:0] OP_INC = 4'd1;
	localparam logic [FUNC_W-1:0] OP_ADD = 4'd2;
	localparam logic [FUNC_W-1:0] OP_SUB = 4'd5;
	localparam logic [FUNC_W-1:0] OP_DEC = 4'd6;
	localparam logic [FUNC_W-1:0] OP_TRC = 4'd7;
	localparam logic [FUNC_W-1:0] OP_AND = 4'd8;
	localparam logic [FUNC_W-1:0] OP_OR  = 4'd10;
	localparam logic [FUNC_W-1:0] OP_XOR = 4'd12;
	localparam logic [FUNC_W-1:0] OP_COM = 4'd14;
	localparam logic [FUNC_W-1:0] OP_HLT = 4'd15;

	typedef enum logic [3:0] {
		FN_PASS = 4'd0,
		FN_INC  = 4'd1,
		FN_ADD  = 4'd2,
		FN_SUB  = 4'd3,
		FN_DEC  = 4'd4,
		FN_AND  = 4'd5,
		FN_OR   = 4'd6,
		FN_XOR  = 4'd7,
		FN_COM  = 4'd8
	} alu_fn_t;

	typedef struct packed {
		alu_fn_t          fn;
		logic             wr;
		logic             upd_zs;
		logic             upd_cv;
		logic             clr_c;
		logic             halt;
		logic             a_ok;
		logic             b_ok;
		logic [SEL_W-1:0] src_a;
		logic [SEL_W-1:0] src_b;
		logic [SEL_W-1:0] dest;
	} dec_t;

endpackage
`default_nettype wire

FILE: hdl/rfalu_if.sv
`default_nettype none
interface rfalu_req_if;
	logic                            valid;
	logic                            ready;
	logic [rfalu_pkg::FUNC_W-1:0]    req_type;
	logic [rfalu_pkg::SEL_W-1:0]     src_a;
	logic [rfalu_pkg::SEL_W-1:0]     src_b;
	logic [rfalu_pkg::SEL_W-1:0]     dest;

	modport source (output valid, req_type, src_a, src_b, dest, input ready);
	modport sink (input valid, req_type, src_a, src_b, dest, output ready);
endinterface

interface rfalu_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [rfalu_pkg::DATA_W-1:0] result_value;
	logic                               wrote;
	logic                               zero_flag;
	logic                               sign_flag;
	logic                               carry_flag;
	logic                               overflow_flag;
	logic                               running;

	modport source (output valid, result_value, wrote, zero_flag, sign_flag, carry_flag,
		overflow_flag, running, input ready);
	modport sink (input valid, result_value, wrote, zero_flag, sign_flag, carry_flag,
		overflow_flag, running, output ready);
endinterface
`default_nettype wire

FILE: hdl/register_file_alu_with_flags.sv
// Channel | Role   | Payload
// req     | sink   | req_type, src_a, src_b, dest
// rsp     | source | result_value, wrote, zero_flag, sign_flag, carry_flag,
//         |        | overflow_flag, running
//
// One item per cycle sustained while rsp is ready; a taken item passes through the queue,
// then the execute stage, where the register file read port feeds the single ALU stage,
// then the output register, with the last write forwarded to the next item.
// Reset clears all flags, sets the run flag and marks every register as zero at once.
// A stalled result leaves the two-entry queue and the execute stage to fill in turn.
`default_nettype none
module register_file_alu_with_flags #(
	parameter int NUM_REGS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rfalu_req_if.sink   req,
	rfalu_rsp_if.source rsp
);
	import rfalu_pkg::*;

	dec_t dec;
	dec_t head;
	logic push;
	logic q_full;
	logic pop;
	logic head_valid;

	rfalu_front #(
		.NUM_REGS(NUM_REGS)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.dec    (dec)
	);

	rfalu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (dec),
		.full      (q_full),
		.pop       (pop),
		.dout      (head),
		.not_empty (head_valid)
	);

	rfalu_back #(
		.NUM_REGS(NUM_REGS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

FILE: hdl/rfalu_ram.sv
`default_nettype none
module rfalu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] ra0,
	input  wire logic [$clog2(DEPTH)-1:0] ra1,
	output logic      [WIDTH-1:0]         rd0,
	output logic      [WIDTH-1:0]         rd1,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wa,
	input  wire logic [WIDTH-1:0]         wd
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd0 <= mem_q[ra0];
			rd1 <= mem_q[ra1];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/rfalu_front.sv
`default_nettype none
module rfalu_front #(
	parameter int NUM_REGS = 8
) (
	rfalu_req_if.sink               req,
	input  wire logic               q_full,
	output logic                    push,
	output rfalu_pkg::dec_t         dec
);
	import rfalu_pkg::*;

	function automatic logic in_range(input logic [SEL_W-1:0] idx);
		return 32'(idx) < NUM_REGS;
	endfunction

	assign req.ready = !q_full;
	assign push = req.valid && !q_full;

	always_comb begin
		dec = '0;
		dec.fn = FN_PASS;
		dec.src_a = req.src_a;
		dec.src_b = req.src_b;
		dec.dest = req.dest;
		dec.a_ok = in_range(req.src_a);
		dec.b_ok = in_range(req.src_b);
		dec.wr = in_range(req.dest);
		unique case (req.req_type)
			OP_TSF: begin
				dec.fn = FN_PASS;
			end
			OP_INC: begin
				dec.fn = FN_INC;
				dec.upd_zs = 1'b1;
			end
			OP_ADD: begin
				dec.fn = FN_ADD;
				dec.upd_zs = 1'b1;
				dec.upd_cv = 1'b1;
			end
			OP_SUB: begin
				dec.fn = FN_SUB;
				dec.upd_zs = 1'b1;
				dec.upd_cv = 1'b1;
			end
			OP_DEC: begin
				dec.fn = FN_DEC;
				dec.upd_zs = 1'b1;
			end
			OP_TRC: begin
				dec.fn = FN_PASS;
				dec.upd_zs = 1'b1;
				dec.clr_c = 1'b1;
			end
			OP_AND: begin
				dec.fn = FN_AND;
				dec.upd_zs = 1'b1;
			end
			OP_OR: begin
				dec.fn = FN_OR;
				dec.upd_zs = 1'b1;
			end
			OP_XOR: begin
				dec.fn = FN_XOR;
				dec.upd_zs = 1'b1;
			end
			OP_COM: begin
				dec.fn = FN_COM;
				dec.upd_zs = 1'b1;
			end
			OP_HLT: begin
				dec.halt = 1'b1;
				dec.wr = 1'b0;
			end
			default: begin
				dec.wr = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/rfalu_queue.sv
`default_nettype none
module rfalu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rfalu_pkg::dec_t din,
	output logic                 full,
	input  wire logic            pop,
	output rfalu_pkg::dec_t      dout,
	output logic                 not_empty
);
	import rfalu_pkg::*;

	dec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/rfalu_back.sv
`default_nettype none
module rfalu_back #(
	parameter int NUM_REGS = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rfalu_pkg::dec_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	rfalu_rsp_if.source          rsp
);
	import rfalu_pkg::*;

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int EXT_W = (IDX_W > SEL_W) ? IDX_W : SEL_W;

	function automatic logic [IDX_W-1:0] to_idx(input logic [SEL_W-1:0] sel);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(sel);
		return ext[IDX_W-1:0];
	endfunction

	dec_t              dec_s2;
	logic              valid_s2;
	logic              fwd_a_s2;
	logic              fwd_b_s2;
	logic              vld_a_s2;
	logic              vld_b_s2;
	logic [DATA_W-1:0] byp_q;
	logic [NUM_REGS-1:0] reg_vld_q;
	logic              z_q, s_q, c_q, v_q, run_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_wrote_q;

	logic [DATA_W-1:0] ram_a, ram_b;
	logic [DATA_W-1:0] op_a, op_b, opnd, res;
	logic [DATA_W:0]   sum;
	logic              cin, ovf;
	logic              z_n, s_n, c_n, v_n, run_n;
	logic              exec_fire, exec_wr;

	assign exec_fire = valid_s2 && (!out_valid_q || rsp.ready);
	assign exec_wr = exec_fire && dec_s2.wr;
	assign pop = head_valid && (!valid_s2 || exec_fire);

	rfalu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_REGS)
	) u_ram (
		.clk (clk),
		.re  (pop),
		.ra0 (to_idx(head.src_a)),
		.ra1 (to_idx(head.src_b)),
		.rd0 (ram_a),
		.rd1 (ram_b),
		.we  (exec_wr),
		.wa  (to_idx(dec_s2.dest)),
		.wd  (res)
	);

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (dec_s2.a_ok) begin
			op_a = fwd_a_s2 ? byp_q : (vld_a_s2 ? ram_a : '0);
		end
		if (dec_s2.b_ok) begin
			op_b = fwd_b_s2 ? byp_q : (vld_b_s2 ? ram_b : '0);
		end

		unique case (dec_s2.fn)
			FN_INC: begin
				opnd = '0;
				cin = 1'b1;
			end
			FN_ADD: begin
				opnd = op_b;
				cin = 1'b0;
			end
			FN_SUB: begin
				opnd = ~op_b;
				cin = 1'b1;
			end
			FN_DEC: begin
				opnd = '1;
				cin = 1'b0;
			end
			default: begin
				opnd = '0;
				cin = 1'b0;
			end
		endcase
		sum = {1'b0, op_a} + {1'b0, opnd} + (DATA_W + 1)'(cin);

		unique case (dec_s2.fn)
			FN_INC, FN_ADD, FN_SUB, FN_DEC: res = sum[DATA_W-1:0];
			FN_AND: res = op_a & op_b;
			FN_OR: res = op_a | op_b;
			FN_XOR: res = op_a ^ op_b;
			FN_COM: res = ~op_a;
			default: res = op_a;
		endcase

		if (dec_s2.fn == FN_SUB) begin
			ovf = ((op_a ^ op_b) & (op_a ^ res)) >> (DATA_W - 1) != '0;
		end else begin
			ovf = (~(op_a ^ op_b) & (op_a ^ res)) >> (DATA_W - 1) != '0;
		end

		z_n = dec_s2.upd_zs ? (res == '0) : z_q;
		s_n = dec_s2.upd_zs ? res[DATA_W-1] : s_q;
		c_n = dec_s2.upd_cv ? sum[DATA_W] : (dec_s2.clr_c ? 1'b0 : c_q);
		v_n = dec_s2.upd_cv ? ovf : v_q;
		run_n = dec_s2.halt ? 1'b0 : run_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dec_s2 <= head;
			fwd_a_s2 <= exec_wr && (dec_s2.dest == head.src_a);
			fwd_b_s2 <= exec_wr && (dec_s2.dest == head.src_b);
			vld_a_s2 <= head.a_ok && reg_vld_q[to_idx(head.src_a)];
			vld_b_s2 <= head.b_ok && reg_vld_q[to_idx(head.src_b)];
		end
		if (exec_wr) begin
			byp_q <= res;
		end
		if (exec_fire) begin
			out_value_q <= dec_s2.wr ? res : '0;
			out_wrote_q <= dec_s2.wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			reg_vld_q <= '0;
			z_q <= 1'b0;
			s_q <= 1'b0;
			c_q <= 1'b0;
			v_q <= 1'b0;
			run_q <= 1'b1;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (exec_fire) begin
				valid_s2 <= 1'b0;
			end
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (exec_wr) begin
				reg_vld_q[to_idx(dec_s2.dest)] <= 1'b1;
			end
			if (exec_fire) begin
				z_q <= z_n;
				s_q <= s_n;
				c_q <= c_n;
				v_q <= v_n;
				run_q <= run_n;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.wrote = out_wrote_q;
	assign rsp.zero_flag = z_q;
	assign rsp.sign_flag = s_q;
	assign rsp.carry_flag = c_q;
	assign rsp.overflow_flag = v_q;
	assign rsp.running = run_q;

endmodule
`default_nettype wire

FILE: hdl/rfalu_chk.sv
`default_nettype none
module rfalu_chk (
	input wire logic    clk,
	input wire logic    arst_n,
	rfalu_req_if.sink   req,
	rfalu_rsp_if.source rsp
);

	logic [2:0] pend_q;
	logic       halted_q;
	logic       in_acc, out_acc;

	assign in_acc = req.valid && req.ready;
	assign out_acc = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			halted_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc && !rsp.running) begin
				halted_q <= 1'b1;
			end
		end
	end

	// A result always belongs to an item taken earlier.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> pend_q != '0)
		else $error("result shown with no item outstanding");

	// Once halted, the run flag stays low until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && halted_q) |-> !rsp.running)
		else $error("run flag came back after halt");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.result_value) && $stable(rsp.wrote))
		else $error("result changed while stalled");

endmodule

bind register_file_alu_with_flags rfalu_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
`default_nettype wire
